/* rtl/core/assert_macros.svh */
// Assertion macros for the top-level RTL file of the ALU block.
// Each macro expects a clock named clk and, where reset matters, a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk; suspended while rst is high.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ebcpu_pkg.sv */
// Types and constants of the 8-bit ALU with flag generation.
// Used by ebcpu_alu and eight_bit_cpu_alu_flags_top; depends on nothing.
package ebcpu_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_ADC   = 4'd1,
    OP_SUB   = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_RLCA  = 4'd5,
    OP_RRCA  = 4'd6,
    OP_RLA   = 4'd7,
    OP_RRA   = 4'd8,
    OP_CPL   = 4'd9,
    OP_SCF   = 4'd10,
    OP_CCF   = 4'd11,
    OP_ADD16 = 4'd12
  } op_t;

  localparam int unsigned FLAG_S = 7;
  localparam int unsigned FLAG_Z = 6;
  localparam int unsigned FLAG_H = 4;
  localparam int unsigned FLAG_P = 2;
  localparam int unsigned FLAG_N = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] BYTE_MAX_POS = 8'h7F;
  localparam logic [7:0] BYTE_MIN_NEG = 8'h80;

  typedef struct packed {
    op_t         op;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [7:0]  flags_in;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0]  byte_result;
    logic [15:0] word_result;
    logic [7:0]  flags_out;
  } alu_res_t;

endpackage

/* rtl/core/eight_bit_cpu_alu_flags_top.sv */
// Top level of the 8-bit ALU with flag generation: stream ports, input and result registers.
// Depends on ebcpu_pkg, ebcpu_alu and assert_macros.svh.
//
// The block takes one item per cycle while not stalled and returns one result item for each,
// in order. An item is captured in the input register, passes once through the ALU logic and
// lands in the result register when that register is empty or being read. The input register
// advances at those times and also whenever it is empty, so the sustained rate is one item per
// cycle, limited only by m_axis_tready; s_axis_tready depends combinationally on m_axis_tready.
// Operation codes 13 to 15 return the accumulator, a zero word and the flags unchanged.
`include "assert_macros.svh"

module eight_bit_cpu_alu_flags_top
  import ebcpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operand_a [7:0], operand_b [15:8], flags_in [23:16], word_a [39:24], word_b [55:40]
  input  logic [55:0] s_axis_tdata,
  // req_type [3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_result [7:0], word_result [23:8], flags_out [31:24]
  output logic [31:0] m_axis_tdata
);

  logic     in_valid;
  alu_req_t in_req;
  logic     out_valid;
  alu_res_t out_res;
  alu_res_t alu_res;
  logic     out_en;
  logic     in_en;

  assign out_en        = ~out_valid | m_axis_tready;
  assign in_en         = ~in_valid | out_en;
  assign s_axis_tready = in_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_en) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_en) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_en && s_axis_tvalid) begin
      in_req.op        <= op_t'(s_axis_tuser);
      in_req.operand_a <= s_axis_tdata[7:0];
      in_req.operand_b <= s_axis_tdata[15:8];
      in_req.flags_in  <= s_axis_tdata[23:16];
      in_req.word_a    <= s_axis_tdata[39:24];
      in_req.word_b    <= s_axis_tdata[55:40];
    end
    if (out_en && in_valid) begin
      out_res <= alu_res;
    end
  end

  ebcpu_alu u_alu (
    .req (in_req),
    .res (alu_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.flags_out, out_res.word_result, out_res.byte_result};

  `ASSERT_CLK(a_item_reaches_output, in_valid && out_en |=> out_valid, "held item was lost")
  `ASSERT_CLK(a_word_zero_unless_add16,
    in_valid && out_en && in_req.op != OP_ADD16 |=> m_axis_tdata[23:8] == 16'd0,
    "word result not zero outside a 16-bit add")
  `ASSERT_CLK(a_subtract_sets_n,
    in_valid && out_en && (in_req.op == OP_SUB || in_req.op == OP_DEC || in_req.op == OP_CPL)
      |=> m_axis_tdata[24 + FLAG_N],
    "N flag clear after a subtracting operation")
  `ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> s_axis_tready,
    "input stalled with an empty result register")

endmodule

/* rtl/core/ebcpu_alu.sv */
// Single-pass ALU datapath: byte and word arithmetic, rotates, complement and flag update.
// Depends on ebcpu_pkg.
module ebcpu_alu
  import ebcpu_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic        add_cin;
  logic [8:0]  sum9;
  logic [4:0]  nib_sum;
  logic [8:0]  diff9;
  logic [4:0]  nib_diff;
  logic [16:0] sum17;
  logic [12:0] low12_sum;
  logic [7:0]  inc_val;
  logic [7:0]  dec_val;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  f;
  logic [7:0]  r;
  logic [15:0] w;

  assign a       = req.operand_a;
  assign b       = req.operand_b;
  assign add_cin = (req.op == OP_ADC) & req.flags_in[FLAG_C];

  assign sum9      = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
  assign nib_sum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
  assign diff9     = {1'b0, a} - {1'b0, b};
  assign nib_diff  = {1'b0, a[3:0]} - {1'b0, b[3:0]};
  assign sum17     = {1'b0, req.word_a} + {1'b0, req.word_b};
  assign low12_sum = {1'b0, req.word_a[11:0]} + {1'b0, req.word_b[11:0]};
  assign inc_val   = b + 8'd1;
  assign dec_val   = b - 8'd1;

  always_comb begin
    f = req.flags_in;
    r = a;
    w = '0;
    unique case (req.op)
      OP_ADD, OP_ADC: begin
        r         = sum9[7:0];
        f[FLAG_H] = nib_sum[4];
        f[FLAG_C] = sum9[8];
        f[FLAG_S] = r[7];
        f[FLAG_Z] = (r == 8'd0);
        f[FLAG_P] = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
        f[FLAG_N] = 1'b0;
      end
      OP_SUB: begin
        r         = diff9[7:0];
        f[FLAG_H] = nib_diff[4];
        f[FLAG_C] = diff9[8];
        f[FLAG_S] = r[7];
        f[FLAG_Z] = (r == 8'd0);
        f[FLAG_P] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
        f[FLAG_N] = 1'b1;
      end
      OP_INC: begin
        r         = inc_val;
        f[FLAG_H] = (b[3:0] == 4'hF);
        f[FLAG_P] = (b == BYTE_MAX_POS);
        f[FLAG_S] = r[7];
        f[FLAG_Z] = (r == 8'd0);
        f[FLAG_N] = 1'b0;
      end
      OP_DEC: begin
        r         = dec_val;
        f[FLAG_H] = (b[3:0] == 4'h0);
        f[FLAG_P] = (b == BYTE_MIN_NEG);
        f[FLAG_S] = r[7];
        f[FLAG_Z] = (r == 8'd0);
        f[FLAG_N] = 1'b1;
      end
      OP_RLCA: begin
        r         = {a[6:0], a[7]};
        f[FLAG_C] = a[7];
        f[FLAG_H] = 1'b0;
        f[FLAG_N] = 1'b0;
      end
      OP_RRCA: begin
        r         = {a[0], a[7:1]};
        f[FLAG_C] = a[0];
        f[FLAG_H] = 1'b0;
        f[FLAG_N] = 1'b0;
      end
      OP_RLA: begin
        r         = {a[6:0], req.flags_in[FLAG_C]};
        f[FLAG_C] = a[7];
        f[FLAG_H] = 1'b0;
        f[FLAG_N] = 1'b0;
      end
      OP_RRA: begin
        r         = {req.flags_in[FLAG_C], a[7:1]};
        f[FLAG_C] = a[0];
        f[FLAG_H] = 1'b0;
        f[FLAG_N] = 1'b0;
      end
      OP_CPL: begin
        r         = ~a;
        f[FLAG_H] = 1'b1;
        f[FLAG_N] = 1'b1;
      end
      OP_SCF: begin
        f[FLAG_C] = 1'b1;
        f[FLAG_H] = 1'b0;
        f[FLAG_N] = 1'b0;
      end
      OP_CCF: begin
        f[FLAG_H] = req.flags_in[FLAG_C];
        f[FLAG_C] = ~req.flags_in[FLAG_C];
        f[FLAG_N] = 1'b0;
      end
      OP_ADD16: begin
        r         = '0;
        w         = sum17[15:0];
        f[FLAG_H] = low12_sum[12];
        f[FLAG_C] = sum17[16];
        f[FLAG_N] = 1'b0;
      end
      default: begin
        r = a;
      end
    endcase
  end

  assign res.byte_result = r;
  assign res.word_result = w;
  assign res.flags_out   = f;

endmodule
